### rtl/gdb_pkg.sv
// Shared types, constants and the arctangent table for the goal distance and bearing block.
package gdb_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int ITERATIONS_DEF  = 16;

	localparam int ANG_W  = 16;
	localparam int DIST_W = 17;
	localparam int GUARD  = 8;
	localparam int Z_W    = 32;

	localparam logic [Z_W-1:0]    INV_GAIN  = 32'h9B74EDA8;
	localparam logic [Z_W-1:0]    Z_HALF    = 32'h80000000;
	localparam logic [Z_W-1:0]    Z_ROUND   = 32'h00008000;
	localparam logic [DIST_W-1:0] DIST_MAX  = 17'h1FFFF;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_GOAL_X = 1'b0,
		REG_GOAL_Y = 1'b1
	} cfg_reg_t;

	// Control group that travels with every beat
	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [ANG_W-1:0] heading;
	} meta_t;

	// Angle of one micro-rotation, atan(2^-i), in units of 2^-32 turn
	function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] i);
		logic [Z_W-1:0] a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			5'd30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

### rtl/gdb_prerot.sv
// Entry stage: goal offset, guard-bit scaling and half-plane pre-rotation.
module gdb_prerot #(
	parameter int CW = 16,
	parameter int XW = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [CW-1:0]         goal_x,
	input  logic signed [CW-1:0]         goal_y,
	input  logic signed [CW-1:0]         pos_x,
	input  logic signed [CW-1:0]         pos_y,
	input  logic [gdb_pkg::ANG_W-1:0]    heading,
	output logic signed [XW-1:0]         x_s1,
	output logic signed [XW-1:0]         y_s1,
	output logic [gdb_pkg::Z_W-1:0]      z_s1,
	output gdb_pkg::meta_t               meta_s1
);
	import gdb_pkg::*;

	localparam int PAD = XW - CW - 1 - GUARD;

	logic signed [CW:0]    dx;
	logic signed [CW:0]    dy;
	logic signed [XW-1:0]  xg;
	logic signed [XW-1:0]  yg;
	logic                  neg;

	// Offset from robot to goal, one bit wider than the coordinates
	assign dx = {goal_x[CW-1], goal_x} - {pos_x[CW-1], pos_x};
	assign dy = {goal_y[CW-1], goal_y} - {pos_y[CW-1], pos_y};

	// Append guard fraction bits and sign-extend to the rotator width
	assign xg = {{PAD{dx[CW]}}, dx, {GUARD{1'b0}}};
	assign yg = {{PAD{dy[CW]}}, dy, {GUARD{1'b0}}};
	assign neg = dx[CW];

	// Payload: flip into the right half-plane, start angle at pi
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= neg ? -xg : xg;
			y_s1 <= neg ? -yg : yg;
			z_s1 <= neg ? Z_HALF : '0;
		end
	end

	// Control: valid, zero-offset flag and heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1.valid   <= in_valid;
			meta_s1.zero    <= (dx == '0) && (dy == '0);
			meta_s1.heading <= heading;
		end
	end

endmodule

### rtl/gdb_rot.sv
// One vectoring micro-rotation stage of the CORDIC pipeline.
module gdb_rot #(
	parameter int XW    = 28,
	parameter int SHIFT = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [XW-1:0]         x_in,
	input  logic signed [XW-1:0]         y_in,
	input  logic [gdb_pkg::Z_W-1:0]      z_in,
	input  gdb_pkg::meta_t               meta_in,
	output logic signed [XW-1:0]         x_s1,
	output logic signed [XW-1:0]         y_s1,
	output logic [gdb_pkg::Z_W-1:0]      z_s1,
	output gdb_pkg::meta_t               meta_s1
);
	import gdb_pkg::*;

	localparam logic [Z_W-1:0] ATAN = atan_turn(5'(SHIFT));

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic                 up;

	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;
	assign up = (y_in > 0);

	// Rotate toward the x axis and accumulate the angle
	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + ATAN;
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - ATAN;
			end
		end
	end

	// Pass the control group along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
		end
	end

endmodule

### rtl/gdb_post.sv
// Output stages: bearing wrap, gain compensation multiply, rounding and saturation.
module gdb_post #(
	parameter int XW = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic signed [XW-1:0]         x_in,
	input  logic [gdb_pkg::Z_W-1:0]      z_in,
	input  gdb_pkg::meta_t               meta_in,
	output logic [gdb_pkg::DIST_W-1:0]   dist_s3,
	output logic [gdb_pkg::ANG_W-1:0]    bearing_s3,
	output logic                         valid_s3
);
	import gdb_pkg::*;

	// Magnitude width, at least one bit above the low multiplier half
	localparam int XPW = (XW > 32) ? XW : 33;
	localparam int RW  = XPW + 2;

	logic [Z_W-1:0]    z_rnd;
	logic [ANG_W-1:0]  ang16;
	logic              xpos;
	logic [XPW-1:0]    ux_s1;
	logic [ANG_W-1:0]  bearing_s1;
	logic [ANG_W-1:0]  bearing_s2;
	logic [63:0]       lo_s2;
	logic [XPW-1:0]    hi_s2;
	logic [RW-1:0]     r_sum;
	logic [RW-1:0]     r_shr;
	logic              valid_s1;
	logic              valid_s2;

	// Round the angle to 16 bits; a zero offset has direction 0
	assign z_rnd = z_in + Z_ROUND;
	assign ang16 = meta_in.zero ? '0 : z_rnd[Z_W-1:Z_W-ANG_W];
	assign xpos  = !meta_in.zero && (x_in > 0);

	// Stage 1: bearing and magnitude operand
	always_ff @(posedge clk) begin
		if (en) begin
			bearing_s1 <= ang16 - meta_in.heading;
			ux_s1      <= xpos ? XPW'($unsigned(x_in)) : '0;
		end
	end

	// Stage 2: partial products of magnitude times inverse gain
	always_ff @(posedge clk) begin
		if (en) begin
			bearing_s2 <= bearing_s1;
			lo_s2      <= 64'(ux_s1[31:0]) * 64'(INV_GAIN);
			hi_s2      <= XPW'(ux_s1[XPW-1:32]) * XPW'(INV_GAIN);
		end
	end

	// Stage 3: sum partials, drop guard bits with rounding, saturate
	assign r_sum = RW'(hi_s2) + RW'(lo_s2[63:32]) + RW'(1 << (GUARD - 1));
	assign r_shr = r_sum >> GUARD;

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_s3 <= bearing_s2;
			dist_s3    <= (r_shr > RW'(DIST_MAX)) ? DIST_MAX : r_shr[DIST_W-1:0];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= meta_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

endmodule

### rtl/goal_distance_and_bearing.sv
// An accepted pose passes the entry stage, the micro-rotation stages and the output stages.
// Throughput: one pose per cycle unless out_stall holds the pipeline; one pipeline stage per CORDIC micro-rotation.
// The whole pipeline holds while a result waits with out_stall high.
// Reset clears all valid bits and sets both goal coordinates to zero.
// Top level: distance and relative bearing from robot pose to the goal point.
module goal_distance_and_bearing #(
	parameter int COORD_WIDTH = gdb_pkg::COORD_WIDTH_DEF,
	parameter int ITERATIONS  = gdb_pkg::ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [gdb_pkg::ANG_W-1:0] heading,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gdb_pkg::DIST_W-1:0]    distance,
	output logic signed [gdb_pkg::ANG_W-1:0] bearing
);
	import gdb_pkg::*;

	localparam int XW = COORD_WIDTH + 12;

	logic signed [COORD_WIDTH-1:0] goal_x_q;
	logic signed [COORD_WIDTH-1:0] goal_y_q;
	logic                          en;
	logic signed [XW-1:0]          x_c [0:ITERATIONS];
	logic signed [XW-1:0]          y_c [0:ITERATIONS];
	logic [Z_W-1:0]                z_c [0:ITERATIONS];
	meta_t                         meta_c [0:ITERATIONS];
	logic [DIST_W-1:0]             dist_w;
	logic [ANG_W-1:0]              bearing_w;

	// Goal registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= '0;
			goal_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GOAL_X: goal_x_q <= cfg_data;
				REG_GOAL_Y: goal_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance everything unless a finished beat is held at the output
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	gdb_prerot #(
		.CW(COORD_WIDTH),
		.XW(XW)
	) u_prerot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.goal_x  (goal_x_q),
		.goal_y  (goal_y_q),
		.pos_x   (pos_x),
		.pos_y   (pos_y),
		.heading (heading),
		.x_s1    (x_c[0]),
		.y_s1    (y_c[0]),
		.z_s1    (z_c[0]),
		.meta_s1 (meta_c[0])
	);

	// Micro-rotation chain, one stage per iteration
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
		gdb_rot #(
			.XW   (XW),
			.SHIFT(i)
		) u_rot (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.x_in   (x_c[i]),
			.y_in   (y_c[i]),
			.z_in   (z_c[i]),
			.meta_in(meta_c[i]),
			.x_s1   (x_c[i+1]),
			.y_s1   (y_c[i+1]),
			.z_s1   (z_c[i+1]),
			.meta_s1(meta_c[i+1])
		);
	end

	gdb_post #(
		.XW(XW)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.x_in      (x_c[ITERATIONS]),
		.z_in      (z_c[ITERATIONS]),
		.meta_in   (meta_c[ITERATIONS]),
		.dist_s3   (dist_w),
		.bearing_s3(bearing_w),
		.valid_s3  (out_valid)
	);

	assign distance = dist_w;
	assign bearing  = $signed(bearing_w);

endmodule

### dv/tb.sv
// Self-checking testbench for goal_distance_and_bearing: random and corner poses against a CORDIC predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gdb_pkg::*;

	localparam int CW          = COORD_WIDTH_DEF;
	localparam int STEPS       = ITERATIONS_DEF;
	localparam int LATENCY     = STEPS + 4;
	localparam int HALF_PERIOD = 5;
	localparam int TIMEOUT_NS  = 4_000_000;
	localparam int HOLD_AFTER  = 700;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 200;

	// atan(2^-i) in units of 2^-32 turn, one entry per micro-rotation
	localparam logic [0:15][31:0] ROT_ANGLE = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef struct packed {
		logic signed [CW-1:0]    px;
		logic signed [CW-1:0]    py;
		logic signed [ANG_W-1:0] hd;
	} pose_t;

	typedef struct packed {
		logic [DIST_W-1:0]       length;
		logic signed [ANG_W-1:0] brg;
	} fix_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [0:0]              cfg_index = REG_GOAL_X;
	logic [CW-1:0]           cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic signed [CW-1:0]    pos_x     = '0;
	logic signed [CW-1:0]    pos_y     = '0;
	logic signed [ANG_W-1:0] heading   = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [DIST_W-1:0]       distance;
	logic signed [ANG_W-1:0] bearing;

	// Goal as last written, seen by the predictor
	logic signed [CW-1:0] goal_x_now = '0;
	logic signed [CW-1:0] goal_y_now = '0;

	pose_t pose_queue[$];
	fix_t  awaited_fixes[$];
	fix_t  want;

	bit bursts_on    = 1'b1;
	bit hold_done    = 1'b0;
	int gap_left     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	int poses_sent   = 0;
	int results_seen = 0;
	int goal_count   = 0;
	int errors       = 0;

	goal_distance_and_bearing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.heading   (heading),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance),
		.bearing   (bearing)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Distance and relative bearing from a pose to the goal, vectoring CORDIC
	function automatic fix_t range_and_bearing(pose_t p, logic signed [CW-1:0] gx,
			logic signed [CW-1:0] gy);
		longint      dx, dy, x, y, xs, ys;
		logic [31:0] z, zr;
		logic [15:0] ang;
		logic [63:0] prod, d;
		int          i;
		fix_t        r;
		dx  = longint'(gx) - longint'(p.px);
		dy  = longint'(gy) - longint'(p.py);
		ang = '0;
		d   = '0;
		if (dx != 0 || dy != 0) begin
			x = dx * (64'sd1 <<< GUARD);
			y = dy * (64'sd1 <<< GUARD);
			z = '0;
			// fold the left half-plane onto the right
			if (x < 0) begin
				x = -x;
				y = -y;
				z = Z_HALF;
			end
			for (i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ROT_ANGLE[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ROT_ANGLE[i];
				end
			end
			zr  = z + Z_ROUND;
			ang = zr[31:16];
			// remove the CORDIC gain and the guard bits
			if (x > 0) begin
				prod = 64'(x) * 64'(INV_GAIN);
				d    = ((prod >> 32) + (64'd1 << (GUARD - 1))) >> GUARD;
			end
			if (d > 64'(DIST_MAX))
				d = 64'(DIST_MAX);
		end
		r.length = d[DIST_W-1:0];
		r.brg    = ang - p.hd;
		return r;
	endfunction

	function automatic pose_t pose(int x, int y, int h);
		pose_t p;
		p.px = CW'(x);
		p.py = CW'(y);
		p.hd = ANG_W'(h);
		return p;
	endfunction

	function automatic int pick_corner();
		int v;
		case ($urandom_range(0, 5))
			0: v = -32768;
			1: v = 32767;
			2: v = 0;
			3: v = -1;
			4: v = 1;
			default: v = int'($urandom_range(0, 65535)) - 32768;
		endcase
		return v;
	endfunction

	// Drain the pipeline, then write both goal coordinates
	task automatic apply_goal(input int gx, input int gy);
		do
			@(negedge clk);
		while (pose_queue.size() != 0 || in_valid || awaited_fixes.size() != 0);
		repeat (LATENCY) @(negedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_GOAL_X;
		cfg_data  <= CW'(gx);
		@(posedge clk);
		cfg_index <= REG_GOAL_Y;
		cfg_data  <= CW'(gy);
		@(posedge clk);
		cfg_we <= 1'b0;
		goal_x_now = CW'(gx);
		goal_y_now = CW'(gy);
		goal_count++;
	endtask

	// Sender: record accepted beats, then offer the next pose or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_fixes.push_back(range_and_bearing({pos_x, pos_y, heading},
					goal_x_now, goal_y_now));
				poses_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pose_queue.size() != 0 && bursts_on &&
						$urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (pose_queue.size() != 0) begin
					{pos_x, pos_y, heading} <= pose_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result beat, then decide the stall for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (awaited_fixes.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: result with none awaited: distance %0d bearing %0d",
							$time, distance, bearing);
				end else begin
					want = awaited_fixes.pop_front();
					if (distance !== want.length) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: distance mismatch, expected %0d actual %0d",
								$time, want.length, distance);
					end
					if (bearing !== want.brg) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: bearing mismatch, expected %0d actual %0d",
								$time, want.brg, bearing);
					end
				end
			end
			// one long hold-off lets the pipeline fill and push back on the input
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 10);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int    ph, n, gx, gy;
		pose_t p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset goal at the origin: zero offset, unit offsets, full-scale corners
		pose_queue.push_back(pose(0, 0, 0));
		pose_queue.push_back(pose(0, 0, 12345));
		pose_queue.push_back(pose(0, 0, -32768));
		pose_queue.push_back(pose(-1, 0, 0));
		pose_queue.push_back(pose(1, 0, 0));
		pose_queue.push_back(pose(0, -1, 0));
		pose_queue.push_back(pose(0, 1, 16384));
		pose_queue.push_back(pose(-32768, -32768, 32767));
		pose_queue.push_back(pose(32767, 32767, -1));
		pose_queue.push_back(pose(32767, -32768, 1));
		pose_queue.push_back(pose(-32768, 0, -16384));
		pose_queue.push_back(pose(5, 5, 0));

		// goal at one corner: largest offsets in both signs
		apply_goal(32767, -32768);
		pose_queue.push_back(pose(-32768, 32767, 0));
		pose_queue.push_back(pose(32767, -32768, -32768));
		pose_queue.push_back(pose(-32768, -32768, 32767));
		pose_queue.push_back(pose(32767, 32767, 0));
		pose_queue.push_back(pose(0, 0, 21845));

		// goal at the opposite corner: offsets pointing left and up
		apply_goal(-32768, 32767);
		pose_queue.push_back(pose(32767, -32768, -21846));
		pose_queue.push_back(pose(32767, 32767, 0));
		pose_queue.push_back(pose(-32768, -32768, 1));
		pose_queue.push_back(pose(-32768, 32767, -1));
		pose_queue.push_back(pose(-32767, 32767, 0));

		// random phases, each under its own goal
		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin gx = 32767;  gy = 32767;  end
				1: begin gx = -32768; gy = -32768; end
				3: begin gx = int'($urandom_range(0, 200)) - 100;
					gy = int'($urandom_range(0, 200)) - 100; end
				default: begin gx = int'($urandom_range(0, 65535)) - 32768;
					gy = int'($urandom_range(0, 65535)) - 32768; end
			endcase
			apply_goal(gx, gy);
			bursts_on = (ph != 2) && (ph != 5);
			n = (ph == 5) ? 150 : 330;
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: p = pose($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535));
					4, 5: p = pose(gx + int'($urandom_range(0, 80)) - 40,
						gy + int'($urandom_range(0, 80)) - 40, $urandom_range(0, 65535));
					6: p = pose(gx, gy, $urandom_range(0, 65535));
					7: p = pose($urandom_range(0, 65535), $urandom_range(0, 65535), 0);
					8: p = pose(pick_corner(), pick_corner(), pick_corner());
					default: begin
						// offset along one axis
						if ($urandom_range(0, 1))
							p = pose(gx, $urandom_range(0, 65535), $urandom_range(0, 65535));
						else
							p = pose($urandom_range(0, 65535), gy, $urandom_range(0, 65535));
					end
				endcase
				pose_queue.push_back(p);
			end
		end

		do
			@(negedge clk);
		while (pose_queue.size() != 0 || in_valid || awaited_fixes.size() != 0);
		repeat (LATENCY + 5) @(posedge clk);

		$display("checked %0d results from %0d poses under %0d goal settings", results_seen,
			poses_sent, goal_count + 1);
		$display("run included zero offsets, full-scale offsets, idle bursts and a long hold-off");
		if (errors == 0)
			$display("goal_distance_and_bearing regression: pass");
		else
			$display("goal_distance_and_bearing regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("timeout after %0d results", results_seen);
		$display("goal_distance_and_bearing regression: fail");
		$finish;
	end

endmodule
